// File: hdl/wrr_pkg.sv
// Package for the weighted round-robin selector.
// Holds field widths, the weight register count and the sequencer states.
// No dependencies.
package wrr_pkg;

	// Fixed field widths
	localparam int unsigned WEIGHT_W    = 8;
	localparam int unsigned NODE_W      = 3;
	localparam int unsigned POS_W       = 11;
	localparam int unsigned WEIGHT_REGS = 8;
	localparam int unsigned CFG_IDX_W   = 3;

	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [NODE_W-1:0]   node_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage : wrr_pkg

// File: hdl/weighted_round_robin_selector.sv
// Weighted round-robin selector: top level, sequencer and shared adder.
// Depends on wrr_pkg.
//
// channel  | handshake            | payload
// ---------+----------------------+-------------------------
// in       | in_valid / in_ready  | up_mask
// out      | out_valid / out_ready| chosen_node, found
// cfg      | cfg_wr_en            | cfg_index, cfg_data
//
// An accepted item runs the sum pass over all NODE_COUNT nodes, then the walk
// pass up to the granted node or the last node, then ST_DONE, from which the
// result is loaded into the output register. One 11-bit adder and comparator
// steps over the nodes, first to add up the weights of up nodes, then to walk
// the running sum until it passes the position.
// in_ready is high only while the sequencer is idle. A result waits in the
// output register until taken; a finished item holds in ST_DONE while the
// previous result is still there. Reset clears weights to 1 and position to 0.
module weighted_round_robin_selector #(
	parameter int unsigned NODE_COUNT = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               up_mask,
	output logic                     out_valid,
	input  logic                     out_ready,
	output wrr_pkg::node_t           chosen_node,
	output logic                     found,
	input  logic                     cfg_wr_en,
	input  logic [wrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wrr_pkg::weight_t         cfg_data
);
	import wrr_pkg::*;

	localparam int unsigned IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

	state_t           state_q, state_d;
	weight_t          weight_q [WEIGHT_REGS];
	logic [7:0]       mask_q;
	logic [IDX_W-1:0] idx_q;
	pos_t             acc_q;
	pos_t             pos_q;
	node_t            res_node_q;
	logic             res_found_q;
	logic             out_valid_q;
	node_t            chosen_node_q;
	logic             found_q;

	logic             is_last;
	logic             node_up;
	weight_t          op_weight;
	pos_t             sum_next;
	logic             walk_hit;
	logic             load_out;

	// Shared unit: one add of the selected weight and one compare against position
	assign node_up   = mask_q[NODE_W'(idx_q)];
	assign op_weight = node_up ? weight_q[NODE_W'(idx_q)] : '0;
	assign sum_next  = acc_q + POS_W'(op_weight);
	assign walk_hit  = node_up && (pos_q < sum_next);
	assign is_last   = (idx_q == LAST_IDX);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SUM;
			end
			ST_SUM: begin
				if (is_last) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_hit || is_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DONE: load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Weight registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(WEIGHT_REGS); i++) weight_q[i] <= WEIGHT_W'(1);
		end else if (cfg_wr_en) begin
			weight_q[cfg_index] <= cfg_data;
		end
	end

	// Position: wraps to zero when it reaches or passes the total, steps by one on a grant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (state_q == ST_SUM && is_last && pos_q >= sum_next) begin
			pos_q <= '0;
		end else if (state_q == ST_WALK && walk_hit) begin
			pos_q <= pos_q + POS_W'(1);
		end
	end

	// Working registers of the two passes
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mask_q      <= up_mask;
				idx_q       <= '0;
				acc_q       <= '0;
				res_node_q  <= '0;
				res_found_q <= 1'b0;
			end
			ST_SUM: begin
				if (is_last) begin
					acc_q <= '0;
					idx_q <= '0;
				end else begin
					acc_q <= sum_next;
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			ST_WALK: begin
				acc_q <= sum_next;
				idx_q <= idx_q + IDX_W'(1);
				if (walk_hit) begin
					res_node_q  <= NODE_W'(idx_q);
					res_found_q <= 1'b1;
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			chosen_node_q <= res_node_q;
			found_q       <= res_found_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign chosen_node = chosen_node_q;
	assign found       = found_q;

	// Checks
	a_accept_starts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SUM)
		else $error("accepted item did not start the sum pass");

	a_none_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> chosen_node == '0)
		else $error("not-found result carries a nonzero node");

	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> 32'(chosen_node) < NODE_COUNT)
		else $error("granted node beyond node count");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(2040))
		else $error("position beyond largest total");

endmodule : weighted_round_robin_selector
